### hw/rtl/lcar_pkg.sv
// Shared types, constants and register indexes for the load-cell converter reader.
// Used by every module of the block; depends on nothing.
package lcar_pkg;

  localparam int NumChannels = 3;
  localparam int MaxChan     = 3;
  localparam int DataBits    = 24;
  localparam int ChanW       = 2;
  localparam int ForceW      = 57;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 32;
  localparam int QueueDepth  = 2;

  localparam logic [DataBits-1:0] ErrMask = 24'h000FFE;
  localparam logic [31:0] ScaleOne = 32'h0001_0000;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgGainPulses = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPulseTicks = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOffset0    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOffset1    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgOffset2    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgScale0     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgScale1     = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgScale2     = 3'd7;

  typedef enum logic [1:0] {
    PhIdle,
    PhData,
    PhFirst,
    PhGain
  } phase_e;

  typedef struct packed {
    logic [1:0] gain_pulses;
    logic [7:0] pulse_ticks;
  } ctrl_cfg_t;

  // One request from the front to the back: either a plain tick or a finished word set.
  typedef struct packed {
    logic                              finish;
    logic                              sck;
    logic [MaxChan-1:0][DataBits-1:0]  words;
    logic [MaxChan-1:0]                flags;
  } job_t;

  typedef struct packed {
    logic                       sck_level;
    logic                       sample_valid;
    logic [ChanW-1:0]           channel;
    logic signed [DataBits-1:0] raw_value;
    logic                       update_ok;
    logic                       line_not_high;
    logic                       last_result;
  } res_t;

endpackage

### hw/rtl/lcar_front.sv
// Front part: runs the shared serial clock sequencer, one input tick per cycle.
// Emits one job per tick into the queue; uses lcar_pkg.
module lcar_front #(
  parameter int NUM_CHANNELS = lcar_pkg::NumChannels
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lcar_pkg::ctrl_cfg_t   cfg_i,
  input  logic                  tick_i,
  input  logic [lcar_pkg::MaxChan-1:0] lines_i,
  output lcar_pkg::job_t        job_o
);

  localparam logic [lcar_pkg::MaxChan-1:0] LineMask =
    lcar_pkg::MaxChan'((1 << NUM_CHANNELS) - 1);

  lcar_pkg::phase_e phase_q, phase_d;
  logic [4:0] pulse_q, pulse_d;
  logic [7:0] tick_q, tick_d;
  logic       clk_high_q, clk_high_d;
  logic [lcar_pkg::MaxChan-1:0][lcar_pkg::DataBits-1:0] shift_q, shift_d;
  logic [lcar_pkg::MaxChan-1:0] nh_q, nh_d;

  logic [lcar_pkg::MaxChan-1:0] lines;
  logic [7:0] period;
  logic [7:0] tick_inc;
  logic       tick_wrap;
  logic       rise;
  logic [1:0] extra;
  logic [4:0] pulse_inc;
  logic       finish_now;

  always_comb begin
    lines     = lines_i & LineMask;
    period    = (cfg_i.pulse_ticks == 8'd0) ? 8'd1 : cfg_i.pulse_ticks;
    tick_inc  = tick_q + 8'd1;
    tick_wrap = (tick_inc >= period);
    rise      = tick_wrap && !clk_high_q;
    extra     = (cfg_i.gain_pulses > 2'd1) ? (cfg_i.gain_pulses - 2'd1) : 2'd0;
    pulse_inc = pulse_q + 5'd1;
    finish_now = rise && (((phase_q == lcar_pkg::PhFirst) && (extra == 2'd0)) ||
                          ((phase_q == lcar_pkg::PhGain) && (pulse_inc >= {3'd0, extra})));
  end

  // Next state.
  always_comb begin
    phase_d    = phase_q;
    pulse_d    = pulse_q;
    tick_d     = tick_q;
    clk_high_d = clk_high_q;
    shift_d    = shift_q;
    nh_d       = nh_q;
    if (phase_q == lcar_pkg::PhIdle) begin
      if (lines == '0) begin
        phase_d    = lcar_pkg::PhData;
        pulse_d    = 5'd0;
        tick_d     = 8'd0;
        clk_high_d = 1'b1;
        shift_d    = '0;
      end
    end else begin
      tick_d = tick_wrap ? 8'd0 : tick_inc;
      if (tick_wrap) begin
        if (clk_high_q) begin
          clk_high_d = 1'b0;
        end else begin
          clk_high_d = 1'b1;
          case (phase_q)
            lcar_pkg::PhData: begin
              for (int c = 0; c < NUM_CHANNELS; c++) begin
                shift_d[c] = {shift_q[c][lcar_pkg::DataBits-2:0], lines[c]};
              end
              pulse_d = pulse_inc;
              if (pulse_inc >= 5'(lcar_pkg::DataBits)) begin
                phase_d = lcar_pkg::PhFirst;
                pulse_d = 5'd0;
              end
            end
            lcar_pkg::PhFirst: begin
              nh_d    = ~lines & LineMask;
              phase_d = lcar_pkg::PhGain;
              pulse_d = 5'd0;
            end
            lcar_pkg::PhGain: begin
              pulse_d = pulse_inc;
            end
            default: begin
              phase_d = lcar_pkg::PhIdle;
            end
          endcase
        end
      end
      if (finish_now) begin
        phase_d    = lcar_pkg::PhIdle;
        clk_high_d = 1'b0;
        tick_d     = 8'd0;
        pulse_d    = 5'd0;
      end
    end
  end

  // Job for the back part.
  always_comb begin
    job_o.finish = finish_now && (phase_q != lcar_pkg::PhIdle);
    job_o.sck    = (phase_q == lcar_pkg::PhIdle) ? 1'b0 : clk_high_q;
    job_o.words  = shift_q;
    // On the first extra pulse the flags come straight from the lines.
    job_o.flags  = (phase_q == lcar_pkg::PhFirst) ? (~lines & LineMask) : nh_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= lcar_pkg::PhIdle;
      pulse_q    <= 5'd0;
      tick_q     <= 8'd0;
      clk_high_q <= 1'b0;
      shift_q    <= '0;
      nh_q       <= '0;
    end else if (tick_i) begin
      phase_q    <= phase_d;
      pulse_q    <= pulse_d;
      tick_q     <= tick_d;
      clk_high_q <= clk_high_d;
      shift_q    <= shift_d;
      nh_q       <= nh_d;
    end
  end

endmodule

### hw/rtl/lcar_queue.sv
// Short job queue between the front and the back part.
// Holds lcar_pkg::job_t entries; uses lcar_pkg.
module lcar_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lcar_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output lcar_pkg::job_t head_o
);

  localparam int Depth = lcar_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  lcar_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/lcar_back.sv
// Back part: turns queued jobs into results, one per cycle while the result side is ready, with the force multiply.
// Keeps the last good word per channel; uses lcar_pkg.
module lcar_back #(
  parameter int NUM_CHANNELS = lcar_pkg::NumChannels
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  lcar_pkg::job_t        head_i,
  output logic                  pop_o,
  input  logic [lcar_pkg::MaxChan-1:0][lcar_pkg::DataBits-1:0] offset_i,
  input  logic [lcar_pkg::MaxChan-1:0][31:0]                   scale_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lcar_pkg::res_t        res_o,
  output logic signed [lcar_pkg::ForceW-1:0] force_o
);

  localparam int DW = lcar_pkg::DataBits;

  logic [lcar_pkg::ChanW-1:0] chan_q;
  logic [lcar_pkg::MaxChan-1:0][DW-1:0] kept_q;

  logic            s1_valid_q;
  lcar_pkg::res_t  s1_res_q;
  logic signed [DW:0]   s1_diff_q;
  logic signed [31:0]   s1_scale_q;

  logic            out_valid_q;
  lcar_pkg::res_t  out_res_q;
  logic signed [lcar_pkg::ForceW-1:0] out_force_q;

  logic            out_free, s1_free, issue, last_chan;
  logic [DW-1:0]   word, raw_sel;
  logic            word_ok;
  lcar_pkg::res_t  res_d;
  logic signed [DW:0]   diff_d;
  logic signed [31:0]   scale_d;
  logic signed [lcar_pkg::ForceW-1:0] prod;

  assign out_free  = !out_valid_q || out_ready_i;
  assign s1_free   = !s1_valid_q || out_free;
  assign issue     = !empty_i && s1_free;
  assign last_chan = (chan_q == lcar_pkg::ChanW'(NUM_CHANNELS - 1));
  assign pop_o     = issue && (!head_i.finish || last_chan);

  always_comb begin
    word    = head_i.words[chan_q];
    word_ok = ((word & lcar_pkg::ErrMask) != lcar_pkg::ErrMask);
    raw_sel = word_ok ? word : kept_q[chan_q];
    if (head_i.finish) begin
      res_d.sck_level     = 1'b0;
      res_d.sample_valid  = 1'b1;
      res_d.channel       = chan_q;
      res_d.raw_value     = raw_sel;
      res_d.update_ok     = word_ok;
      res_d.line_not_high = head_i.flags[chan_q];
      res_d.last_result   = last_chan;
      diff_d  = $signed({raw_sel[DW-1], raw_sel}) -
                $signed({offset_i[chan_q][DW-1], offset_i[chan_q]});
      scale_d = scale_i[chan_q];
    end else begin
      res_d.sck_level     = head_i.sck;
      res_d.sample_valid  = 1'b0;
      res_d.channel       = '0;
      res_d.raw_value     = '0;
      res_d.update_ok     = 1'b0;
      res_d.line_not_high = 1'b0;
      res_d.last_result   = 1'b1;
      diff_d  = '0;
      scale_d = '0;
    end
  end

  assign prod = s1_diff_q * s1_scale_q;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_res_q   <= res_d;
      s1_diff_q  <= diff_d;
      s1_scale_q <= scale_d;
    end
    if (out_free && s1_valid_q) begin
      out_res_q   <= s1_res_q;
      out_force_q <= prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q      <= '0;
      kept_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue && head_i.finish) begin
        chan_q <= last_chan ? '0 : chan_q + 1'b1;
        if (word_ok) begin
          kept_q[chan_q] <= word;
        end
      end
      if (s1_free) begin
        s1_valid_q <= issue;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_res_q;
  assign force_o     = out_force_q;

endmodule

### hw/rtl/load_cell_adc_reader.sv
// Top level of the load-cell converter reader: configuration registers, front, queue, back.
// Depends on lcar_pkg, lcar_front, lcar_queue and lcar_back.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_ready_o   dout_lines_i
//   result    out        out_valid_o / out_ready_i sck_level_o .. last_result_o
//   config    in         cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// One tick is accepted per cycle while the two-entry job queue has room.
// A plain tick's result passes through the queue, the multiply stage and the output register.
// A finishing tick gives NUM_CHANNELS results through the shared multiplier on consecutive
// cycles while the result side is ready; back-to-back ticks can see in_ready_o low meanwhile.
// Reset is asynchronous and returns the sequencer to idle with the clock low.
// A stalled result side fills the queue and then holds in_ready_o low.
module load_cell_adc_reader #(
  parameter int NUM_CHANNELS = lcar_pkg::NumChannels
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lcar_pkg::MaxChan-1:0]        dout_lines_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                sck_level_o,
  output logic                                sample_valid_o,
  output logic [lcar_pkg::ChanW-1:0]          channel_o,
  output logic signed [lcar_pkg::DataBits-1:0] raw_value_o,
  output logic signed [lcar_pkg::ForceW-1:0]  force_value_o,
  output logic                                update_ok_o,
  output logic                                line_not_high_o,
  output logic                                last_result_o,
  input  logic                                cfg_we_i,
  input  logic [lcar_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [lcar_pkg::CfgDataW-1:0]       cfg_wdata_i
);

  lcar_pkg::ctrl_cfg_t ctrl_q;
  logic [lcar_pkg::MaxChan-1:0][lcar_pkg::DataBits-1:0] offset_q;
  logic [lcar_pkg::MaxChan-1:0][31:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.gain_pulses <= 2'd1;
      ctrl_q.pulse_ticks <= 8'd1;
      offset_q           <= '0;
      for (int c = 0; c < lcar_pkg::MaxChan; c++) begin
        scale_q[c] <= lcar_pkg::ScaleOne;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lcar_pkg::CfgGainPulses: ctrl_q.gain_pulses <= cfg_wdata_i[1:0];
        lcar_pkg::CfgPulseTicks: ctrl_q.pulse_ticks <= cfg_wdata_i[7:0];
        lcar_pkg::CfgOffset0:    offset_q[0] <= cfg_wdata_i[lcar_pkg::DataBits-1:0];
        lcar_pkg::CfgOffset1:    offset_q[1] <= cfg_wdata_i[lcar_pkg::DataBits-1:0];
        lcar_pkg::CfgOffset2:    offset_q[2] <= cfg_wdata_i[lcar_pkg::DataBits-1:0];
        lcar_pkg::CfgScale0:     scale_q[0]  <= cfg_wdata_i;
        lcar_pkg::CfgScale1:     scale_q[1]  <= cfg_wdata_i;
        lcar_pkg::CfgScale2:     scale_q[2]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  lcar_pkg::job_t front_job, head_job;
  logic q_full, q_empty, q_pop, tick_fire;
  lcar_pkg::res_t res;

  assign in_ready_o = !q_full;
  assign tick_fire  = in_valid_i && !q_full;

  lcar_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (ctrl_q),
    .tick_i  (tick_fire),
    .lines_i (dout_lines_i),
    .job_o   (front_job)
  );

  lcar_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (tick_fire),
    .push_data_i (front_job),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_job)
  );

  lcar_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head_job),
    .pop_o       (q_pop),
    .offset_i    (offset_q),
    .scale_i     (scale_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .force_o     (force_value_o)
  );

  assign sck_level_o     = res.sck_level;
  assign sample_valid_o  = res.sample_valid;
  assign channel_o       = res.channel;
  assign raw_value_o     = res.raw_value;
  assign update_ok_o     = res.update_ok;
  assign line_not_high_o = res.line_not_high;
  assign last_result_o   = res.last_result;

endmodule

### hw/rtl/lcar_checker.sv
// Port-level checker for load_cell_adc_reader, attached by the bind below.
// Depends on lcar_pkg and on the top level's ports.
module lcar_checker #(
  parameter int NUM_CHANNELS = lcar_pkg::NumChannels
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic                                 sck_level_o,
  input logic                                 sample_valid_o,
  input logic [lcar_pkg::ChanW-1:0]           channel_o,
  input logic signed [lcar_pkg::DataBits-1:0] raw_value_o,
  input logic signed [lcar_pkg::ForceW-1:0]   force_value_o,
  input logic                                 update_ok_o,
  input logic                                 last_result_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(raw_value_o) && $stable(force_value_o) &&
      $stable(channel_o) && $stable(last_result_o))
    else $error("stalled result payload changed");

  a_sample_clock_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_valid_o |-> !sck_level_o)
    else $error("reading delivered with the serial clock high");

  a_plain_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sample_valid_o |-> last_result_o && (channel_o == '0) &&
      !update_ok_o && (raw_value_o == '0) && (force_value_o == '0))
    else $error("plain tick result carries reading fields");

  a_last_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_valid_o |->
      (last_result_o == (channel_o == lcar_pkg::ChanW'(NUM_CHANNELS - 1))))
    else $error("last reading marker does not match the last channel");

endmodule

bind load_cell_adc_reader lcar_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_lcar_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .sck_level_o    (sck_level_o),
  .sample_valid_o (sample_valid_o),
  .channel_o      (channel_o),
  .raw_value_o    (raw_value_o),
  .force_value_o  (force_value_o),
  .update_ok_o    (update_ok_o),
  .last_result_o  (last_result_o)
);
